// ===== sv/pts_pkg.sv =====
// ---------------------------------------------------------------------------
// pts_pkg
// Shared widths, codes and stage payload types of the piecewise-linear
// tanh / sigmoid unit.
// ---------------------------------------------------------------------------
package pts_pkg;

   // Field and datapath widths.
   localparam int DATA_WIDTH = 16;
   localparam int MAG_W      = 15;
   localparam int RES_W      = 14;
   localparam int OUT_W      = 15;
   localparam int PREC_W     = 4;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Precision limits and reset value.
   localparam logic [PREC_W-1:0] PREC_MIN   = 4'd6;
   localparam logic [PREC_W-1:0] PREC_MAX   = 4'd13;
   localparam logic [PREC_W-1:0] PREC_RESET = 4'd10;

   // Function select codes.
   typedef enum logic [0:0] {
      CMD_TANH    = 1'b0,
      CMD_SIGMOID = 1'b1
   } cmd_type;

   // Register indexes.
   typedef enum logic [0:0] {
      REG_FRAC_BITS = 1'b0
   } reg_index_type;

   // Payload after the front stage: magnitude to feed the segment stage.
   typedef struct packed {
      cmd_type             cmd;
      logic                neg;
      logic [PREC_W-1:0]   prec;
      logic [MAG_W-1:0]    mag;
   } front_type;

   // Payload after the segment stage: tanh of the magnitude.
   typedef struct packed {
      cmd_type             cmd;
      logic                neg;
      logic [PREC_W-1:0]   prec;
      logic [RES_W-1:0]    tanh_mag;
   } seg_type;

endpackage

// ===== sv/pts_csr.sv =====
// ---------------------------------------------------------------------------
// pts_csr
// Configuration register block: holds frac_bits and supplies the clamped
// precision to the datapath.
// ---------------------------------------------------------------------------
module pts_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pts_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pts_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pts_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [pts_pkg::PREC_W-1:0]      prec
);
   import pts_pkg::*;

   logic [PREC_W-1:0] frac_bits_ff;
   logic [PREC_W-1:0] frac_bits_in;
   reg_index_type     reg_index;
   logic              wr_hit;

   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register write decode; unknown indexes are dropped.
   always_comb begin
      frac_bits_in = frac_bits_ff;
      if (wr_hit) begin
         case (reg_index)
            REG_FRAC_BITS: frac_bits_in = csr_pwdata[PREC_W-1:0];
            default:       frac_bits_in = frac_bits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_bits_ff <= PREC_RESET;
      end else begin
         frac_bits_ff <= frac_bits_in;
      end
   end

   // Read mux.
   always_comb begin
      case (reg_index)
         REG_FRAC_BITS: csr_prdata = {{(CSR_DATA_W-PREC_W){1'b0}}, frac_bits_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // The datapath only sees precisions in the supported range.
   always_comb begin
      if (frac_bits_ff < PREC_MIN) begin
         prec = PREC_MIN;
      end else if (frac_bits_ff > PREC_MAX) begin
         prec = PREC_MAX;
      end else begin
         prec = frac_bits_ff;
      end
   end

endmodule

// ===== sv/pts_front.sv =====
// ---------------------------------------------------------------------------
// pts_front
// First pipeline stage: saturating magnitude, sign capture and the halving
// of the argument for sigmoid.
// ---------------------------------------------------------------------------
module pts_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                in_cmd,
   input  logic signed [pts_pkg::DATA_WIDTH-1:0] in_operand,
   input  logic [pts_pkg::PREC_W-1:0]          prec,
   output logic                                out_valid,
   input  logic                                out_ready,
   output pts_pkg::front_type                  out_data
);
   import pts_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   front_type data_ff;
   front_type data_in;
   logic [MAG_W-1:0] mag;

   // The stage takes a beat when it is empty or its beat moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Magnitude, with the most negative code saturated first.
   always_comb begin
      if (!in_operand[DATA_WIDTH-1]) begin
         mag = in_operand[MAG_W-1:0];
      end else if (in_operand == {1'b1, {(DATA_WIDTH-1){1'b0}}}) begin
         mag = {MAG_W{1'b1}};
      end else begin
         mag = MAG_W'(-in_operand);
      end
   end

   always_comb begin
      data_in.cmd  = cmd_type'(in_cmd);
      data_in.neg  = in_operand[DATA_WIDTH-1];
      data_in.prec = prec;
      data_in.mag  = (cmd_type'(in_cmd) == CMD_SIGMOID) ? (mag >> 1) : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/pts_seg.sv =====
// ---------------------------------------------------------------------------
// pts_seg
// Second pipeline stage: segment compare and the five-piece tanh
// approximation of the magnitude.
// ---------------------------------------------------------------------------
module pts_seg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pts_pkg::front_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output pts_pkg::seg_type    out_data
);
   import pts_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   seg_type data_ff;
   seg_type data_in;

   logic [DATA_WIDTH-1:0] m;
   logic [DATA_WIDTH-1:0] fourth;
   logic [DATA_WIDTH-1:0] half;
   logic [DATA_WIDTH-1:0] one;
   logic [DATA_WIDTH-1:0] three_fourth;
   logic [DATA_WIDTH-1:0] one_fourth;
   logic [DATA_WIDTH-1:0] two_fourth;
   logic [DATA_WIDTH-1:0] five_64;
   logic [DATA_WIDTH-1:0] one_32;
   logic [DATA_WIDTH-1:0] quarter_m;
   logic [DATA_WIDTH-1:0] knee;
   logic [DATA_WIDTH-1:0] r;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Breakpoints and offsets at the current precision.
   always_comb begin
      m            = DATA_WIDTH'(in_data.mag);
      fourth       = DATA_WIDTH'(1) << (in_data.prec - 4'd2);
      half         = DATA_WIDTH'(1) << (in_data.prec - 4'd1);
      one          = DATA_WIDTH'(1) << in_data.prec;
      three_fourth = (fourth << 1) + fourth;
      one_fourth   = one + fourth;
      two_fourth   = (one << 1) + fourth;
      five_64      = (DATA_WIDTH'(5)) << (in_data.prec - 4'd6);
      one_32       = DATA_WIDTH'(1) << (in_data.prec - 4'd5);
      quarter_m    = m >> 2;
   end

   // Piece select; the last sloped piece clamps at one.
   always_comb begin
      knee = (m >> 3) + (half + fourth - one_32);
      if (m <= fourth) begin
         r = m;
      end else if (m <= three_fourth) begin
         r = (quarter_m << 1) + quarter_m + five_64;
      end else if (m <= one_fourth) begin
         r = (m >> 1) + fourth;
      end else if (m <= two_fourth) begin
         r = (knee > one) ? one : knee;
      end else begin
         r = one;
      end
   end

   always_comb begin
      data_in.cmd      = in_data.cmd;
      data_in.neg      = in_data.neg;
      data_in.prec     = in_data.prec;
      data_in.tanh_mag = r[RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/pts_back.sv =====
// ---------------------------------------------------------------------------
// pts_back
// Third pipeline stage and output register: sigmoid offset, sign restore
// and mirroring.
// ---------------------------------------------------------------------------
module pts_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  pts_pkg::seg_type                      in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [pts_pkg::OUT_W-1:0]      out_value
);
   import pts_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [OUT_W-1:0]  value_ff;
   logic [OUT_W-1:0]  value_in;
   logic [RES_W-1:0]  one;
   logic [RES_W:0]    sum;
   logic [RES_W-1:0]  sig;
   logic [RES_W-1:0]  sig_signed;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Sigmoid is the tanh value lifted by one and halved, mirrored below zero.
   always_comb begin
      one        = RES_W'(1) << in_data.prec;
      sum        = {1'b0, in_data.tanh_mag} + {1'b0, one};
      sig        = sum[RES_W:1];
      sig_signed = in_data.neg ? (one - sig) : sig;
   end

   always_comb begin
      case (in_data.cmd)
         CMD_SIGMOID: value_in = {1'b0, sig_signed};
         CMD_TANH: begin
            if (in_data.neg) begin
               value_in = -{1'b0, in_data.tanh_mag};
            end else begin
               value_in = {1'b0, in_data.tanh_mag};
            end
         end
         default: value_in = {1'b0, in_data.tanh_mag};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         value_ff <= value_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

endmodule

// ===== sv/pwl_tanh_sigmoid_unit_top.sv =====
// ---------------------------------------------------------------------------
// pwl_tanh_sigmoid_unit_top
// Piecewise-linear tanh and sigmoid in signed fixed point, with the
// number of fraction bits set through the configuration port.
// ---------------------------------------------------------------------------
// Throughput: one beat per cycle through three register stages (front,
// segment, back); each stage holds its beat only while the next one stalls.
// Reset clears every stage valid bit and sets frac_bits to 10.
// ---------------------------------------------------------------------------
module pwl_tanh_sigmoid_unit_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic signed [pts_pkg::DATA_WIDTH-1:0] req_operand_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pts_pkg::OUT_W-1:0]      rsp_activation_value,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pts_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [pts_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [pts_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import pts_pkg::*;

   logic [PREC_W-1:0] prec;
   logic              front_ready;
   logic              front_valid;
   front_type         front_data;
   logic              seg_ready;
   logic              seg_valid;
   seg_type           seg_data;
   logic              back_ready;

   // Configuration registers.
   pts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .prec        (prec)
   );

   // Stage one: magnitude.
   pts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (front_ready),
      .in_cmd     (req_cmd),
      .in_operand (req_operand_value),
      .prec       (prec),
      .out_valid  (front_valid),
      .out_ready  (seg_ready),
      .out_data   (front_data)
   );

   // Stage two: segment evaluation.
   pts_seg u_seg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (seg_ready),
      .in_data   (front_data),
      .out_valid (seg_valid),
      .out_ready (back_ready),
      .out_data  (seg_data)
   );

   // Stage three: sign and sigmoid finish.
   pts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (back_ready),
      .in_data   (seg_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_value (rsp_activation_value)
   );

   assign req_stall = !front_ready;

   // The input only stalls when every stage is holding a beat.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (front_valid && seg_valid && rsp_valid))
      else $error("request stalled while a pipeline stage was empty");

   // A front beat that cannot move on is held unchanged.
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (front_valid && !seg_ready) |=> (front_valid && $stable(front_data)))
      else $error("front stage beat changed while stalled");

   // The tanh magnitude never exceeds one at the beat's precision.
   a_tanh_bound: assert property (@(posedge clock) disable iff (reset)
      seg_valid |-> (seg_data.tanh_mag <= (RES_W'(1) << seg_data.prec)))
      else $error("tanh magnitude above one");

   // The carried precision stays inside the supported range.
   a_prec_range: assert property (@(posedge clock) disable iff (reset)
      seg_valid |-> (seg_data.prec >= PREC_MIN && seg_data.prec <= PREC_MAX))
      else $error("precision out of range in segment stage");

endmodule
